[rtl/dirty_cell_ansi_renderer_macros.svh]
// Assertion macros shared by the renderer checks.
`ifndef DIRTY_CELL_ANSI_RENDERER_MACROS_SVH
`define DIRTY_CELL_ANSI_RENDERER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCAR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcar: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DCAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcar: next-cycle check failed");

`endif

[rtl/dcar_pkg.sv]
// Shared types and constants of the dirty-cell ANSI renderer.
`timescale 1ns / 1ps
package dcar_pkg;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_SHOWN = 3'd4;

    // Bytes of the escape sequences
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_LO_H   = 8'h68;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_M   = 8'h6D;

    // One unit of work for the byte generator
    typedef struct packed {
        logic        fe;        // frame end
        logic        show;      // frame end: restore and show cursor
        logic        pos;       // emit cursor position
        logic        fg_on;     // emit foreground escape
        logic        bg_on;     // emit background escape
        logic [15:0] row_bcd;   // 1-based row, 4 BCD digits
        logic [15:0] col_bcd;   // 1-based column, 4 BCD digits
        logic [23:0] fg;
        logic [23:0] bg;
        logic [2:0]  ulen;      // character bytes, 1..4
        logic [31:0] ubytes;    // first byte in the top lane
    } job_t;

endpackage

[rtl/dcar_fifo.sv]
// Short job queue between the classifier and the byte generator.
`timescale 1ns / 1ps
module dcar_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dcar_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output dcar_pkg::job_t head,
    output logic          empty
);
    import dcar_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= QPTR_W'(wr_reg + 1'b1);
            end
            if (pop) begin
                rd_reg <= QPTR_W'(rd_reg + 1'b1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/dcar_front.sv]
// Front end: accepts cells, tracks position and terminal state, queues jobs.
`timescale 1ns / 1ps
module dcar_front #(
    parameter int MAX_DIM = 1024,
    parameter int DIM_W   = 11
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_op,
    input  logic [31:0]    s_new_char,
    input  logic [23:0]    s_new_fg,
    input  logic [23:0]    s_new_bg,
    input  logic [31:0]    s_old_char,
    input  logic [23:0]    s_old_fg,
    input  logic [23:0]    s_old_bg,
    input  logic [10:0]    frame_width,
    input  logic [10:0]    frame_height,
    input  logic [9:0]     cursor_col,
    input  logic [9:0]     cursor_row,
    input  logic           cursor_shown,
    input  logic           q_full,
    output logic           push,
    output dcar_pkg::job_t job
);
    import dcar_pkg::*;

    localparam logic [31:0] CP_1B = 32'h0000_007F;
    localparam logic [31:0] CP_2B = 32'h0000_07FF;
    localparam logic [31:0] CP_3B = 32'h0000_FFFF;
    localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (32'(v) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] r;
        logic        c;
        r = v;
        c = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (c) begin
                if (r[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Values up to 1024; reciprocal multiplies stand in for the divides
    function automatic logic [15:0] bin_to_bcd(input logic [10:0] v);
        logic        th;
        logic [9:0]  r;
        logic [15:0] p;
        logic [3:0]  h;
        logic [6:0]  r2;
        logic [14:0] q;
        logic [3:0]  t;
        logic [3:0]  o;
        th = (v >= 11'd1000);
        r  = th ? 10'(v - 11'd1000) : v[9:0];
        p  = 16'(r) * 16'd41;
        h  = p[15:12];
        r2 = 7'(r - 10'(h) * 10'd100);
        q  = 15'(r2) * 15'd205;
        t  = q[14:11];
        o  = 4'(r2 - 7'(t) * 7'd10);
        return {3'b000, th, h, t, o};
    endfunction

    logic [DIM_W-1:0] col_reg, row_reg, term_col_reg, term_row_reg;
    logic             term_known_reg, first_reg;
    logic [23:0]      sent_fg_reg, sent_bg_reg;
    logic [15:0]      col_bcd_reg, row_bcd_reg;

    logic [DIM_W-1:0] w, h;
    logic             accept, past, changed, pos_need, wrap;
    logic [2:0]       ulen;
    logic [31:0]      ubytes;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign w        = clamp_dim(frame_width);
    assign h        = clamp_dim(frame_height);
    assign past     = (row_reg >= h);
    assign changed  = (s_new_char != s_old_char) || (s_new_fg != s_old_fg)
                   || (s_new_bg != s_old_bg);
    assign pos_need = !term_known_reg || (term_col_reg != col_reg) || (term_row_reg != row_reg);
    assign wrap     = (({1'b0, col_reg} + 1'b1) >= {1'b0, w});
    assign push     = accept && (s_op || (!past && changed));

    always_comb begin
        if (s_new_char <= CP_1B) begin
            ulen   = 3'd1;
            ubytes = {s_new_char[7:0], 24'h0};
        end else if (s_new_char <= CP_2B) begin
            ulen   = 3'd2;
            ubytes = {3'b110, s_new_char[10:6], 2'b10, s_new_char[5:0], 16'h0};
        end else if (s_new_char <= CP_3B) begin
            ulen   = 3'd3;
            ubytes = {4'b1110, s_new_char[15:12], 2'b10, s_new_char[11:6],
                      2'b10, s_new_char[5:0], 8'h0};
        end else if (s_new_char <= CP_MAX) begin
            ulen   = 3'd4;
            ubytes = {5'b11110, s_new_char[20:18], 2'b10, s_new_char[17:12],
                      2'b10, s_new_char[11:6], 2'b10, s_new_char[5:0]};
        end else begin
            ulen   = 3'd1;
            ubytes = {CH_QMARK, 24'h0};
        end
    end

    always_comb begin
        job.fe      = s_op;
        job.show    = cursor_shown;
        job.pos     = s_op ? cursor_shown : pos_need;
        job.fg_on   = !s_op && (first_reg || (s_new_fg != sent_fg_reg));
        job.bg_on   = !s_op && (first_reg || (s_new_bg != sent_bg_reg));
        job.row_bcd = s_op ? bin_to_bcd(11'(cursor_row) + 11'd1) : row_bcd_reg;
        job.col_bcd = s_op ? bin_to_bcd(11'(cursor_col) + 11'd1) : col_bcd_reg;
        job.fg      = s_new_fg;
        job.bg      = s_new_bg;
        job.ulen    = ulen;
        job.ubytes  = ubytes;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            col_bcd_reg    <= 16'h0001;
            row_bcd_reg    <= 16'h0001;
            term_col_reg   <= '0;
            term_row_reg   <= '0;
            term_known_reg <= 1'b0;
            sent_fg_reg    <= '0;
            sent_bg_reg    <= '0;
            first_reg      <= 1'b1;
        end else if (accept) begin
            if (s_op) begin
                col_reg        <= '0;
                row_reg        <= '0;
                col_bcd_reg    <= 16'h0001;
                row_bcd_reg    <= 16'h0001;
                term_col_reg   <= '0;
                term_row_reg   <= '0;
                term_known_reg <= 1'b0;
                sent_fg_reg    <= '0;
                sent_bg_reg    <= '0;
                first_reg      <= 1'b1;
            end else if (!past) begin
                if (changed) begin
                    sent_fg_reg    <= s_new_fg;
                    sent_bg_reg    <= s_new_bg;
                    first_reg      <= 1'b0;
                    term_col_reg   <= DIM_W'(col_reg + 1'b1);
                    term_row_reg   <= row_reg;
                    term_known_reg <= 1'b1;
                end
                if (wrap) begin
                    col_reg     <= '0;
                    col_bcd_reg <= 16'h0001;
                    row_reg     <= DIM_W'(row_reg + 1'b1);
                    row_bcd_reg <= bcd_inc(row_bcd_reg);
                end else begin
                    col_reg     <= DIM_W'(col_reg + 1'b1);
                    col_bcd_reg <= bcd_inc(col_bcd_reg);
                end
            end
        end
    end

endmodule

[rtl/dcar_back.sv]
// Back end: turns queued jobs into the output byte stream, one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps
module dcar_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  dcar_pkg::job_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_byte
);
    import dcar_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_POS_LEAD = 7'b0000010,
        ST_POS_NUM  = 7'b0000100,
        ST_CLR_LEAD = 7'b0001000,
        ST_CLR_NUM  = 7'b0010000,
        ST_CHR      = 7'b0100000,
        ST_TAIL     = 7'b1000000
    } st_t;

    // 8-bit value to three BCD digits
    function automatic logic [11:0] dec3(input logic [7:0] v);
        logic [15:0] p;
        logic [3:0]  hd;
        logic [7:0]  r;
        logic [14:0] q;
        logic [3:0]  t;
        p  = 16'(v) * 16'd41;
        hd = p[15:12];
        r  = 8'(v - 8'(hd) * 8'd100);
        q  = 15'(r) * 15'd205;
        t  = q[14:11];
        return {hd, t, 4'(r - 8'(t) * 8'd10)};
    endfunction

    st_t        st_reg, st_next;
    job_t       job_reg, job_next;
    logic [2:0] sub_reg, sub_next;
    logic       sel_reg, sel_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] dig_reg, dig_next;
    logic       started_reg, started_next;
    logic       term_reg, term_next;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_last_reg;

    logic        go, last;
    logic [7:0]  byte_now;
    logic [23:0] cur_color;
    logic [7:0]  comp_byte;
    logic [15:0] num_bcd;
    logic [1:0]  msd, eff;
    logic [3:0]  digit;

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_last_byte = m_last_reg;
    assign go          = !m_valid_reg || m_ready;

    assign cur_color = sel_reg ? job_reg.bg : job_reg.fg;

    always_comb begin
        case (comp_reg)
            2'd0:    comp_byte = cur_color[23:16];
            2'd1:    comp_byte = cur_color[15:8];
            default: comp_byte = cur_color[7:0];
        endcase
        if (st_reg == ST_POS_NUM) begin
            num_bcd = sel_reg ? job_reg.col_bcd : job_reg.row_bcd;
        end else begin
            num_bcd = {4'h0, dec3(comp_byte)};
        end
        if (num_bcd[15:12] != 4'h0) begin
            msd = 2'd3;
        end else if (num_bcd[11:8] != 4'h0) begin
            msd = 2'd2;
        end else if (num_bcd[7:4] != 4'h0) begin
            msd = 2'd1;
        end else begin
            msd = 2'd0;
        end
        eff   = started_reg ? dig_reg : msd;
        digit = num_bcd[4*eff +: 4];
    end

    always_comb begin
        st_next      = st_reg;
        job_next     = job_reg;
        sub_next     = sub_reg;
        sel_next     = sel_reg;
        comp_next    = comp_reg;
        dig_next     = dig_reg;
        started_next = started_reg;
        term_next    = term_reg;
        q_pop        = 1'b0;
        byte_now     = 8'h00;
        last         = 1'b0;

        case (st_reg)
            ST_IDLE: begin
                byte_now = 8'h00;
            end
            ST_POS_LEAD: begin
                byte_now = (sub_reg == 3'd0) ? CH_ESC : CH_LBRACK;
                if (go) begin
                    if (sub_reg == 3'd1) begin
                        st_next      = ST_POS_NUM;
                        sel_next     = 1'b0;
                        started_next = 1'b0;
                        term_next    = 1'b0;
                    end else begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            ST_POS_NUM: begin
                if (term_reg) begin
                    byte_now = sel_reg ? CH_UP_H : CH_SEMI;
                    if (go) begin
                        started_next = 1'b0;
                        term_next    = 1'b0;
                        sub_next     = 3'd0;
                        if (!sel_reg) begin
                            sel_next = 1'b1;
                        end else if (job_reg.fe) begin
                            st_next = ST_TAIL;
                        end else if (job_reg.fg_on) begin
                            st_next  = ST_CLR_LEAD;
                            sel_next = 1'b0;
                        end else if (job_reg.bg_on) begin
                            st_next  = ST_CLR_LEAD;
                            sel_next = 1'b1;
                        end else begin
                            st_next = ST_CHR;
                        end
                    end
                end else begin
                    byte_now = CH_ZERO | {4'h0, digit};
                    if (go) begin
                        if (eff == 2'd0) begin
                            term_next = 1'b1;
                        end else begin
                            dig_next     = eff - 2'd1;
                            started_next = 1'b1;
                        end
                    end
                end
            end
            ST_CLR_LEAD: begin
                case (sub_reg)
                    3'd0:    byte_now = CH_ESC;
                    3'd1:    byte_now = CH_LBRACK;
                    3'd2:    byte_now = sel_reg ? CH_FOUR : CH_THREE;
                    3'd3:    byte_now = CH_EIGHT;
                    3'd4:    byte_now = CH_SEMI;
                    3'd5:    byte_now = CH_TWO;
                    default: byte_now = CH_SEMI;
                endcase
                if (go) begin
                    if (sub_reg == 3'd6) begin
                        st_next      = ST_CLR_NUM;
                        comp_next    = 2'd0;
                        started_next = 1'b0;
                        term_next    = 1'b0;
                    end else begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            ST_CLR_NUM: begin
                if (term_reg) begin
                    byte_now = (comp_reg == 2'd2) ? CH_LO_M : CH_SEMI;
                    if (go) begin
                        started_next = 1'b0;
                        term_next    = 1'b0;
                        sub_next     = 3'd0;
                        if (comp_reg != 2'd2) begin
                            comp_next = comp_reg + 2'd1;
                        end else if (!sel_reg && job_reg.bg_on) begin
                            st_next  = ST_CLR_LEAD;
                            sel_next = 1'b1;
                        end else begin
                            st_next = ST_CHR;
                        end
                    end
                end else begin
                    byte_now = CH_ZERO | {4'h0, digit};
                    if (go) begin
                        if (eff == 2'd0) begin
                            term_next = 1'b1;
                        end else begin
                            dig_next     = eff - 2'd1;
                            started_next = 1'b1;
                        end
                    end
                end
            end
            ST_CHR: begin
                case (sub_reg)
                    3'd0:    byte_now = job_reg.ubytes[31:24];
                    3'd1:    byte_now = job_reg.ubytes[23:16];
                    3'd2:    byte_now = job_reg.ubytes[15:8];
                    default: byte_now = job_reg.ubytes[7:0];
                endcase
                last = ((sub_reg + 3'd1) == job_reg.ulen);
                if (go) begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_TAIL: begin
                case (sub_reg)
                    3'd0:    byte_now = CH_ESC;
                    3'd1:    byte_now = CH_LBRACK;
                    3'd2:    byte_now = CH_QMARK;
                    3'd3:    byte_now = CH_TWO;
                    3'd4:    byte_now = CH_FIVE;
                    default: byte_now = job_reg.show ? CH_LO_H : CH_LO_L;
                endcase
                last = (sub_reg == 3'd5);
                if (go) begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // Next job loads as the last byte leaves, so jobs run back to back
        if ((st_reg == ST_IDLE) || (go && last)) begin
            if (!q_empty) begin
                q_pop        = 1'b1;
                job_next     = q_head;
                sub_next     = 3'd0;
                comp_next    = 2'd0;
                dig_next     = 2'd0;
                started_next = 1'b0;
                term_next    = 1'b0;
                sel_next     = 1'b0;
                if (q_head.pos) begin
                    st_next = ST_POS_LEAD;
                end else if (q_head.fe) begin
                    st_next = ST_TAIL;
                end else if (q_head.fg_on) begin
                    st_next = ST_CLR_LEAD;
                end else if (q_head.bg_on) begin
                    st_next  = ST_CLR_LEAD;
                    sel_next = 1'b1;
                end else begin
                    st_next = ST_CHR;
                end
            end else begin
                st_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        sub_reg     <= sub_next;
        sel_reg     <= sel_next;
        comp_reg    <= comp_next;
        dig_reg     <= dig_next;
        started_reg <= started_next;
        term_reg    <= term_next;
        if (go) begin
            m_byte_reg <= byte_now;
            m_last_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (go) begin
                m_valid_reg <= (st_reg != ST_IDLE);
            end
        end
    end

endmodule

[rtl/dirty_cell_ansi_renderer.sv]
// Top level of the dirty-cell ANSI renderer.
`timescale 1ns / 1ps
// Screen cells come in raster order on the s_ channel; each changed cell becomes a run
// of terminal bytes on the m_ channel (cursor move when needed, truecolor escapes when
// the color differs from the last sent, then the character as UTF-8), and an end-of-frame
// item becomes a cursor restore-and-show or a hide sequence. Rate: unchanged cells and
// cells past the last row are taken one per cycle; a changed cell's bytes go out one per
// cycle through the single-byte output register while not stalled. A four-entry job queue
// sits between the classifier and the byte generator, and the byte generator holds one
// more job, so up to five changed or frame-end items can be taken while the output is
// stalled; once the queue is full the input stalls, unchanged cells included. The byte
// generator moves from one item's last byte to the next item's first byte with no gap.
// Configuration writes are accepted every cycle and take effect from the next item.
module dirty_cell_ansi_renderer #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcar_pkg::CFG_DATA_W-1:0]   cfg_data,
    // cell items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [31:0]                       s_new_char,
    input  logic [23:0]                       s_new_fg,
    input  logic [23:0]                       s_new_bg,
    input  logic [31:0]                       s_old_char,
    input  logic [23:0]                       s_old_fg,
    input  logic [23:0]                       s_old_bg,
    // output byte items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_last_byte
);
    import dcar_pkg::*;

    // counters must reach MAX_DIM itself
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [10:0] frame_width_reg, frame_height_reg;
    logic [9:0]  cursor_col_reg, cursor_row_reg;
    logic        cursor_shown_reg;

    logic q_full, q_empty, q_push, q_pop;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 11'd80;
            frame_height_reg <= 11'd24;
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            cursor_shown_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_CURSOR_COL:   cursor_col_reg   <= cfg_data[9:0];
                CFG_CURSOR_ROW:   cursor_row_reg   <= cfg_data[9:0];
                CFG_CURSOR_SHOWN: cursor_shown_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify cells, track position and terminal state
    dcar_front #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_new_char   (s_new_char),
        .s_new_fg     (s_new_fg),
        .s_new_bg     (s_new_bg),
        .s_old_char   (s_old_char),
        .s_old_fg     (s_old_fg),
        .s_old_bg     (s_old_bg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cursor_col   (cursor_col_reg),
        .cursor_row   (cursor_row_reg),
        .cursor_shown (cursor_shown_reg),
        .q_full       (q_full),
        .push         (q_push),
        .job          (push_job)
    );

    dcar_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_job),
        .empty     (q_empty)
    );

    // serialize jobs into bytes
    dcar_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

[rtl/dcar_checker.sv]
// Port-level checks of the renderer output stream, bound to the top level.
`timescale 1ns / 1ps
`include "dirty_cell_ansi_renderer_macros.svh"
module dcar_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_byte
);
    import dcar_pkg::*;

    // stalled output holds
    `DCAR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_last_byte))

    // an escape inside a run is always followed right away by a bracket
    `DCAR_ASSERT_NEXT(a_esc_bracket, aclk, aresetn, m_valid && m_ready && (m_out_byte == CH_ESC) && !m_last_byte, !m_valid || (m_out_byte == CH_LBRACK))

    // a UTF-8 lead byte is followed right away by a continuation byte
    `DCAR_ASSERT_NEXT(a_utf8_cont, aclk, aresetn, m_valid && m_ready && (m_out_byte[7:6] == 2'b11), !m_valid || (m_out_byte[7:6] == 2'b10))

    // a UTF-8 lead byte never ends a run
    `DCAR_ASSERT_SAME(a_lead_not_last, aclk, aresetn, m_valid && (m_out_byte[7:6] == 2'b11), !m_last_byte)

endmodule

bind dirty_cell_ansi_renderer dcar_checker u_dcar_checker (.*);
